[rtl/tdts_pkg.sv]
// Package for the tick-driven task scheduler: transaction structs, codes and
// the token that travels along the row of slot cells.
// Depends on nothing; every module of the scheduler imports it.
package tdts_pkg;

	// Most dispatch results that one dispatch transaction may carry.
	localparam int MAX_OUT = 8;
	localparam int CNT_W   = 4;

	typedef enum logic [1:0] {
		KIND_ADD      = 2'd0,
		KIND_DELETE   = 2'd1,
		KIND_TICK     = 2'd2,
		KIND_DISPATCH = 2'd3
	} kind_e_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2,
		STATUS_NONE  = 2'd3
	} status_e_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_SCAN = 1'b1
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] task_id;
		logic [15:0] first_delay;
		logic [15:0] period;
		logic [2:0]  slot;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  slot_out;
		logic [15:0] task_out;
		logic        last;
	} result_t;

	// Scan token handed from cell to cell, one cell per cycle.
	typedef struct packed {
		logic             valid;
		logic             is_add;
		logic             found;
		logic [CNT_W-1:0] cnt;
	} token_t;

	// Signals broadcast to every cell at once.
	typedef struct packed {
		logic        tick;
		logic [15:0] task_id;
		logic [15:0] first_delay;
		logic [15:0] period;
	} bcast_t;

	// Result raised by the cell that holds the token; all zero otherwise.
	typedef struct packed {
		logic        valid;
		logic [2:0]  slot;
		logic [15:0] task_id;
	} cell_res_t;

endpackage

[rtl/tdts_cell.sv]
// One task slot of the scheduler: holds the slot state, applies ticks and
// deletes, and serves the scan token passed along the row.
// Depends on tdts_pkg.
module tdts_cell
	import tdts_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  bcast_t    bcast,
	input  logic      del,
	input  token_t    tok_in,
	output token_t    tok_out,
	output cell_res_t res,
	output logic      occ
);

	logic        occ_q;
	logic [15:0] handle_q;
	logic [16:0] cd_q;
	logic [15:0] per_q;
	logic [7:0]  runs_q;
	token_t      tok_q;

	logic        take_add;
	logic        take_disp;
	logic [16:0] cd_dec;
	token_t      tok_nxt;

	always_comb begin
		take_add  = tok_in.valid && tok_in.is_add && !tok_in.found && !occ_q;
		take_disp = tok_in.valid && !tok_in.is_add && (tok_in.cnt < CNT_W'(MAX_OUT))
			&& (runs_q != 8'd0);
		cd_dec    = cd_q - 17'd1;

		tok_nxt       = tok_in;
		tok_nxt.found = tok_in.found | take_add;
		tok_nxt.cnt   = tok_in.cnt + CNT_W'(take_disp);

		res.valid   = take_add | take_disp;
		res.slot    = (take_add | take_disp) ? 3'(IDX) : 3'd0;
		res.task_id = take_disp ? handle_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= 1'b0;
			handle_q <= '0;
			cd_q     <= '0;
			per_q    <= '0;
			runs_q   <= '0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (del) begin
				occ_q    <= 1'b0;
				handle_q <= '0;
				cd_q     <= '0;
				per_q    <= '0;
				runs_q   <= '0;
			end else if (bcast.tick && occ_q && (cd_q != 17'd0)) begin
				if (cd_dec == 17'd0) begin
					if (runs_q != 8'hFF)
						runs_q <= runs_q + 8'd1;
					// A one-shot slot parks at zero and never fires again.
					cd_q <= {1'b0, per_q};
				end else begin
					cd_q <= cd_dec;
				end
			end else if (take_add) begin
				occ_q    <= 1'b1;
				handle_q <= bcast.task_id;
				cd_q     <= {1'b0, bcast.first_delay} + 17'd1;
				per_q    <= bcast.period;
				runs_q   <= '0;
			end else if (take_disp) begin
				if (per_q == 16'd0) begin
					occ_q    <= 1'b0;
					handle_q <= '0;
					cd_q     <= '0;
					per_q    <= '0;
					runs_q   <= '0;
				end else begin
					runs_q <= runs_q - 8'd1;
				end
			end
		end
	end

	assign tok_out = tok_q;
	assign occ     = occ_q;

endmodule

[rtl/tick_driven_task_scheduler.sv]
// Tick-driven task scheduler: a row of SLOTS task cells, a scan token that
// walks the row for add and dispatch, and the result sequencing.
// Depends on tdts_pkg and tdts_cell.
//
// Tick and delete transactions leave busy low; the delete result appears in the
// cycle after acceptance. Add and dispatch send a token down the row of cells,
// one cell per cycle, so busy stays high until the token leaves the last cell,
// and no new transaction is accepted while busy is high. Dispatch results come
// out as the token passes ready slots, at most one per cycle, with the final one
// (last set) in the same cycle as busy falls. Results are strobed by
// result_valid for a single cycle and cannot be held off, so the receiver must
// take every strobe. Only slots 0 to 7 can be deleted.
module tick_driven_task_scheduler
	import tdts_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    result_valid,
	output result_t result
);

	state_t    state_q, state_nxt;
	item_t     cmd_q;
	token_t    tok0_q;
	cell_res_t hold_q;
	result_t   result_q;
	logic      result_valid_q;

	logic      accept;
	logic      scan_go;
	logic      del_go;
	logic      del_occ;
	logic      del_in_range;
	logic      scan_end;
	bcast_t    bcast;
	cell_res_t cell_res;
	result_t   out_d;
	logic      out_valid_d;

	token_t     tok_chain [SLOTS+1];
	cell_res_t  res_vec   [SLOTS];
	logic [SLOTS-1:0] occ_vec;
	logic [SLOTS-1:0] sel_vec;
	logic [SLOTS-1:0] res_valid_vec;
	logic [SLOTS:0]   tok_valid_vec;

	assign busy    = (state_q == ST_SCAN);
	assign accept  = start && !busy;
	assign scan_go = accept && ((item.kind == KIND_ADD) || (item.kind == KIND_DISPATCH));
	assign del_go  = accept && (item.kind == KIND_DELETE);

	assign bcast.tick        = accept && (item.kind == KIND_TICK);
	assign bcast.task_id     = cmd_q.task_id;
	assign bcast.first_delay = cmd_q.first_delay;
	assign bcast.period      = cmd_q.period;

	assign tok_chain[0] = tok0_q;
	assign scan_end     = tok_chain[SLOTS].valid;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			assign sel_vec[gi] = (32'(item.slot) == gi);
			tdts_cell #(
				.IDX(gi)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.bcast  (bcast),
				.del    (del_go && sel_vec[gi]),
				.tok_in (tok_chain[gi]),
				.tok_out(tok_chain[gi+1]),
				.res    (res_vec[gi]),
				.occ    (occ_vec[gi])
			);
			assign res_valid_vec[gi] = res_vec[gi].valid;
		end
		for (gi = 0; gi <= SLOTS; gi++) begin : g_tokv
			assign tok_valid_vec[gi] = tok_chain[gi].valid;
		end
	endgenerate

	assign del_in_range = (32'(item.slot) < SLOTS);
	assign del_occ      = |(occ_vec & sel_vec);

	// Only the cell holding the token drives a non-zero result.
	always_comb begin
		cell_res = '0;
		for (int i = 0; i < SLOTS; i++)
			cell_res = cell_res | res_vec[i];
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (scan_go) state_nxt = ST_SCAN;
			ST_SCAN: if (scan_end) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	// A found slot is held back in hold_q so that the final one can carry last.
	always_comb begin
		out_d       = '0;
		out_valid_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (del_go) begin
					out_valid_d    = 1'b1;
					out_d.status   = (del_in_range && del_occ) ? STATUS_OK : STATUS_EMPTY;
					out_d.slot_out = item.slot;
					out_d.last     = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					out_valid_d = 1'b1;
					out_d.last  = 1'b1;
					if (hold_q.valid) begin
						out_d.status   = STATUS_OK;
						out_d.slot_out = hold_q.slot;
						out_d.task_out = hold_q.task_id;
					end else begin
						out_d.status = cmd_q.kind == KIND_ADD ? STATUS_FULL : STATUS_NONE;
					end
				end else if (cell_res.valid && hold_q.valid) begin
					out_valid_d    = 1'b1;
					out_d.status   = STATUS_OK;
					out_d.slot_out = hold_q.slot;
					out_d.task_out = hold_q.task_id;
				end
			end
			default: out_valid_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tok0_q         <= '0;
			hold_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_nxt;
			result_valid_q <= out_valid_d;
			tok0_q         <= '0;
			if (scan_go) begin
				tok0_q.valid  <= 1'b1;
				tok0_q.is_add <= (item.kind == KIND_ADD);
			end
			if (state_q == ST_SCAN) begin
				if (scan_end)
					hold_q <= '0;
				else if (cell_res.valid)
					hold_q <= cell_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= out_d;
		if (accept)
			cmd_q <= item;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid_vec))
		else $error("more than one scan token in the cell row");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(res_valid_vec))
		else $error("more than one cell raised a result in one cycle");

	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && scan_end) |=> !busy)
		else $error("scan ended but busy stayed high");

	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q.valid |-> busy)
		else $error("held result outside a scan");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|tok_valid_vec) |-> busy)
		else $error("scan token present while not busy");
`endif

endmodule

[sim/tb_tick_driven_task_scheduler.sv]
// Self-checking testbench for the tick-driven task scheduler: a directed table followed by
// random add, delete, tick and dispatch transactions, checked against a local slot table.
// Depends on rtl/tdts_pkg.sv, rtl/tdts_cell.sv and rtl/tick_driven_task_scheduler.sv.
`timescale 1ns / 1ps

module tb_tick_driven_task_scheduler;
	import tdts_pkg::*;

	localparam int SLOTS        = 8;
	localparam int RANDOM_ITEMS = 60;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	item_t   item = '0;
	logic    busy;
	logic    result_valid;
	result_t result;

	// Typed-in expectation that travels with the directed transaction on the bus.
	bit      tx_typed = 1'b0;
	result_t tx_res = '0;

	int          idle_pct = 0;
	int          errors = 0;
	int unsigned cycle_count = 0;
	result_t     due_results[$];
	row_t        directed[$];

	// Expected contents of the slot table.
	logic        occ   [SLOTS];
	logic [15:0] hnd   [SLOTS];
	logic [16:0] cdn   [SLOTS];
	logic [15:0] rel   [SLOTS];
	logic [7:0]  runs  [SLOTS];

	tick_driven_task_scheduler #(
		.SLOTS(SLOTS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic result_t mk_res(status_e_t st, logic [2:0] so, logic [15:0] t, logic l);
		result_t r;
		r.status   = st;
		r.slot_out = so;
		r.task_out = t;
		r.last     = l;
		return r;
	endfunction

	function automatic row_t mk_row(kind_e_t k, logic [15:0] id, logic [15:0] dly,
			logic [15:0] per, logic [2:0] sl, bit typed = 1'b0,
			status_e_t st = STATUS_OK, logic [2:0] so = 3'd0);
		row_t r;
		r.it.kind        = k;
		r.it.task_id     = id;
		r.it.first_delay = dly;
		r.it.period      = per;
		r.it.slot        = sl;
		r.typed          = typed;
		r.res            = mk_res(st, so, 16'd0, 1'b1);
		return r;
	endfunction

	function automatic item_t rand_item();
		item_t   it;
		int      pick;
		pick = $urandom_range(99);
		if (pick < 25)
			it.kind = KIND_ADD;
		else if (pick < 40)
			it.kind = KIND_DELETE;
		else if (pick < 75)
			it.kind = KIND_TICK;
		else
			it.kind = KIND_DISPATCH;
		it.task_id = 16'($urandom);
		// Short delays and periods keep tasks firing; the odd full-range value reaches the top bits.
		it.first_delay = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
		pick = $urandom_range(9);
		if (pick < 3)
			it.period = 16'd0;
		else if (pick < 9)
			it.period = 16'($urandom_range(4, 1));
		else
			it.period = 16'($urandom);
		it.slot = 3'($urandom_range(7));
		return it;
	endfunction

	task automatic clear_entry(int i);
		occ[i]  = 1'b0;
		hnd[i]  = 16'd0;
		cdn[i]  = 17'd0;
		rel[i]  = 16'd0;
		runs[i] = 8'd0;
	endtask

	// Applies one accepted transaction to the expected table and, if asked, queues its results.
	task automatic advance_table(input item_t it, input bit keep);
		int      i;
		int      n;
		result_t r;
		result_t outs[$];
		case (it.kind)
			KIND_ADD: begin
				i = 0;
				while (i < SLOTS && occ[i])
					i++;
				if (i >= SLOTS) begin
					outs.push_back(mk_res(STATUS_FULL, 3'd0, 16'd0, 1'b1));
				end else begin
					occ[i]  = 1'b1;
					hnd[i]  = it.task_id;
					cdn[i]  = {1'b0, it.first_delay} + 17'd1;
					rel[i]  = it.period;
					runs[i] = 8'd0;
					outs.push_back(mk_res(STATUS_OK, 3'(i), 16'd0, 1'b1));
				end
			end
			KIND_DELETE: begin
				if (int'(it.slot) >= SLOTS) begin
					outs.push_back(mk_res(STATUS_EMPTY, it.slot, 16'd0, 1'b1));
				end else begin
					outs.push_back(mk_res(occ[it.slot] ? STATUS_OK : STATUS_EMPTY,
						it.slot, 16'd0, 1'b1));
					clear_entry(int'(it.slot));
				end
			end
			KIND_TICK: begin
				for (i = 0; i < SLOTS; i++) begin
					if (occ[i] && cdn[i] != 17'd0) begin
						cdn[i] = cdn[i] - 17'd1;
						if (cdn[i] == 17'd0) begin
							if (runs[i] != 8'hFF)
								runs[i] = runs[i] + 8'd1;
							if (rel[i] != 16'd0)
								cdn[i] = {1'b0, rel[i]};
						end
					end
				end
			end
			default: begin
				n = 0;
				for (i = 0; i < SLOTS && n < MAX_OUT; i++) begin
					if (runs[i] != 8'd0) begin
						outs.push_back(mk_res(STATUS_OK, 3'(i), hnd[i], 1'b0));
						n++;
						runs[i] = runs[i] - 8'd1;
						if (rel[i] == 16'd0)
							clear_entry(i);
					end
				end
				if (n == 0) begin
					outs.push_back(mk_res(STATUS_NONE, 3'd0, 16'd0, 1'b1));
				end else begin
					r = outs.pop_back();
					r.last = 1'b1;
					outs.push_back(r);
				end
			end
		endcase
		if (keep)
			foreach (outs[k])
				due_results.push_back(outs[k]);
	endtask

	// Results are compared first: nothing accepted at this edge can have produced one yet.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: status %0d slot_out %0d task_out %0h last %0b",
						result.status, result.slot_out, result.task_out, result.last);
					errors++;
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						errors++;
					end
					if (result.slot_out !== want.slot_out) begin
						$error("slot_out: expected %0d, got %0d", want.slot_out, result.slot_out);
						errors++;
					end
					if (result.task_out !== want.task_out) begin
						$error("task_out: expected %0h, got %0h", want.task_out, result.task_out);
						errors++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result.last);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				advance_table(item, !tx_typed);
				if (tx_typed)
					due_results.push_back(tx_res);
			end
		end
	end

	task automatic send(input item_t it, input bit typed, input result_t res);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		item     <= it;
		tx_typed <= typed;
		tx_res   <= res;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		item_t it;
		int    p;
		for (int i = 0; i < SLOTS; i++)
			clear_entry(i);

		directed.push_back(mk_row(KIND_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0, 1'b1, STATUS_NONE, 3'd0));
		directed.push_back(mk_row(KIND_DELETE, 16'h0, 16'h0, 16'h0, 3'd7, 1'b1, STATUS_EMPTY, 3'd7));
		directed.push_back(mk_row(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7));
		directed.push_back(mk_row(KIND_ADD, 16'hFFFF, 16'h0000, 16'h0000, 3'd0, 1'b1, STATUS_OK, 3'd0));
		directed.push_back(mk_row(KIND_ADD, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, STATUS_OK, 3'd1));
		directed.push_back(mk_row(KIND_ADD, 16'h1234, 16'h0000, 16'h0001, 3'd0, 1'b1, STATUS_OK, 3'd2));
		directed.push_back(mk_row(KIND_ADD, 16'hA5A5, 16'h0001, 16'h0000, 3'd0, 1'b1, STATUS_OK, 3'd3));
		directed.push_back(mk_row(KIND_ADD, 16'h5A5A, 16'h0002, 16'h0002, 3'd0, 1'b1, STATUS_OK, 3'd4));
		directed.push_back(mk_row(KIND_ADD, 16'h00FF, 16'h0000, 16'h0000, 3'd0, 1'b1, STATUS_OK, 3'd5));
		directed.push_back(mk_row(KIND_ADD, 16'hFF00, 16'h0000, 16'h0003, 3'd0, 1'b1, STATUS_OK, 3'd6));
		directed.push_back(mk_row(KIND_ADD, 16'h8001, 16'h0000, 16'h0000, 3'd0, 1'b1, STATUS_OK, 3'd7));
		directed.push_back(mk_row(KIND_ADD, 16'h7FFE, 16'h0005, 16'h0005, 3'd0, 1'b1, STATUS_FULL, 3'd0));
		// The second tick must leave fired one-shot tasks alone.
		directed.push_back(mk_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_DELETE, 16'h0, 16'h0, 16'h0, 3'd1, 1'b1, STATUS_OK, 3'd1));
		directed.push_back(mk_row(KIND_DELETE, 16'h0, 16'h0, 16'h0, 3'd1, 1'b1, STATUS_EMPTY, 3'd1));
		directed.push_back(mk_row(KIND_DELETE, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_ADD, 16'hC3C3, 16'h0000, 16'h0000, 3'd0));
		directed.push_back(mk_row(KIND_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
		directed.push_back(mk_row(KIND_DELETE, 16'h0, 16'h0, 16'h0, 3'd6));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[r])
			send(directed[r].it, directed[r].typed, directed[r].res);

		for (p = 0; p < 3; p++) begin
			idle_pct = (p == 1) ? 53 : ((p == 2) ? 17 : 0);
			for (int n = 0; n < RANDOM_ITEMS / 3; n++)
				send(rand_item(), 1'b0, '0);
			if (p == 0) begin
				// Empty the table, then let a period-one task pile up enough runs to saturate.
				// After 256 ticks a wrapped count would read zero, so the dispatches show it.
				for (int s = 0; s < SLOTS; s++) begin
					it = rand_item();
					it.kind = KIND_DELETE;
					it.slot = 3'(s);
					send(it, 1'b0, '0);
				end
				it = rand_item();
				it.kind = KIND_ADD;
				it.first_delay = 16'd0;
				it.period = 16'd1;
				send(it, 1'b0, '0);
				for (int t = 0; t < 256; t++) begin
					it.kind = KIND_TICK;
					send(it, 1'b0, '0);
				end
				it.kind = KIND_DISPATCH;
				repeat (3) send(it, 1'b0, '0);
			end
		end
		start <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (2 * SLOTS + 4) @(posedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
